// File: src/fsfl_pkg.sv
// ----------------------------------------------------------------------------
// fsfl_pkg: shared definitions for the fixed slot free list allocator
// Field widths, register indexes, status codes and the command record that
// travels from the front end to the list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package fsfl_pkg;

  localparam int unsigned MAX_SLOTS_DEF      = 1024;
  localparam int unsigned MAX_SLOT_BYTES_DEF = 4096;

  localparam int unsigned SLOT_BYTES_W = 13;
  localparam int unsigned SLOT_COUNT_W = 11;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned SIZE_W       = 16;
  localparam int unsigned OFF_W        = 22;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned GSLOT_W      = 10;
  localparam int unsigned COUNT_W      = 11;
  localparam int unsigned DIV_CNT_W    = $clog2(OFF_W);
  localparam int unsigned CMDQ_DEPTH   = 2;

  localparam logic [SLOT_BYTES_W-1:0] SLOT_BYTES_RST = 13'd64;
  localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RST = 11'd1024;
  localparam logic [COUNT_W-1:0]      COUNT_MAX      = 11'd2047;
  localparam int unsigned             MIN_SLOT_BYTES = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOT_BYTES = 1'b0,
    CFG_SLOT_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_RANGE     = 3'd3,
    ST_MISALIGN  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_REJECT = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    status_t   status;
  } cmd_t;

endpackage

`default_nettype wire

// File: src/fsfl_req_if.sv
// ----------------------------------------------------------------------------
// fsfl_req_if: request channel
// Valid/ready channel carrying one allocate or free request per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface fsfl_req_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [fsfl_pkg::SIZE_W-1:0]       request_size;
  logic [fsfl_pkg::OFF_W-1:0]        freed_offset;

  modport source (output valid, req_type, request_size, freed_offset, input ready);
  modport sink   (input valid, req_type, request_size, freed_offset, output ready);
endinterface

`default_nettype wire

// File: src/fsfl_rsp_if.sv
// ----------------------------------------------------------------------------
// fsfl_rsp_if: response channel
// Valid/ready channel carrying one result per request transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface fsfl_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [fsfl_pkg::STATUS_W-1:0]     status;
  logic [fsfl_pkg::GSLOT_W-1:0]      granted_slot;
  logic [fsfl_pkg::OFF_W-1:0]        granted_offset;
  logic [fsfl_pkg::COUNT_W-1:0]      free_count;

  modport source (output valid, status, granted_slot, granted_offset, free_count,
                  input ready);
  modport sink   (input valid, status, granted_slot, granted_offset, free_count,
                  output ready);
endinterface

`default_nettype wire

// File: src/fsfl_front.sv
// ----------------------------------------------------------------------------
// fsfl_front: request classifier and offset divider
// Checks allocate sizes, turns free offsets into slot indexes with a
// restoring divider (one quotient bit per cycle) and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module fsfl_front #(
  parameter int unsigned SW  = 10,
  parameter int unsigned EBW = 13,
  parameter int unsigned CNTW = 11
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  fsfl_req_if.sink               in_ch,
  input  wire logic [EBW-1:0]    eff_bytes,
  input  wire logic [CNTW-1:0]   eff_count,
  input  wire logic              sweeping,
  input  wire logic              cfg_we,
  input  wire logic              q_full,
  output logic                   push,
  output fsfl_pkg::cmd_t         cmd_ctl,
  output logic [SW-1:0]          cmd_idx
);

  localparam int unsigned OFF_W = fsfl_pkg::OFF_W;
  localparam int unsigned SZW   = (EBW > fsfl_pkg::SIZE_W) ? EBW : fsfl_pkg::SIZE_W;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t                          state_r, state_nxt;
  logic [OFF_W-1:0]                 quo_r, quo_nxt;
  logic [EBW-1:0]                   rem_r, rem_nxt;
  logic [fsfl_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [EBW:0]                     trial;
  logic                             accept;
  logic                             div_last;

  assign in_ch.ready = (state_r == F_IDLE) && !sweeping && !cfg_we && !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign trial       = {rem_r, quo_r[OFF_W-1]};
  assign div_last    = (cnt_r == fsfl_pkg::DIV_CNT_W'(OFF_W - 1));
  assign cmd_idx     = quo_r[SW-1:0];

  always_comb begin
    state_nxt = state_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    push      = 1'b0;
    cmd_ctl   = '{kind: fsfl_pkg::CMD_ALLOC, status: fsfl_pkg::ST_OK};
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          if (fsfl_pkg::req_t'(in_ch.req_type) == fsfl_pkg::REQ_ALLOC) begin
            push = 1'b1;
            if (SZW'(in_ch.request_size) > SZW'(eff_bytes)) begin
              cmd_ctl = '{kind: fsfl_pkg::CMD_REJECT, status: fsfl_pkg::ST_TOO_LARGE};
            end
          end else begin
            quo_nxt   = in_ch.freed_offset;
            rem_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = F_DIV;
          end
        end
      end
      F_DIV: begin
        // The dividend shifts out of the top of quo_r while quotient bits
        // shift in at the bottom.
        if (trial >= {1'b0, eff_bytes}) begin
          rem_nxt = EBW'(trial - {1'b0, eff_bytes});
          quo_nxt = {quo_r[OFF_W-2:0], 1'b1};
        end else begin
          rem_nxt = EBW'(trial);
          quo_nxt = {quo_r[OFF_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (div_last) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (rem_r != '0) begin
          cmd_ctl = '{kind: fsfl_pkg::CMD_REJECT, status: fsfl_pkg::ST_MISALIGN};
        end else if (quo_r >= OFF_W'(eff_count)) begin
          cmd_ctl = '{kind: fsfl_pkg::CMD_REJECT, status: fsfl_pkg::ST_RANGE};
        end else begin
          cmd_ctl = '{kind: fsfl_pkg::CMD_FREE, status: fsfl_pkg::ST_OK};
        end
        if (!q_full) begin
          push      = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  a_div_ends_in_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_DIV) && div_last |=> state_r == F_PUSH)
    else $error("divider did not hand over to the push step");

  a_free_is_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    push && (cmd_ctl.kind == fsfl_pkg::CMD_FREE) |-> (rem_r == '0) && (state_r == F_PUSH))
    else $error("free command queued with a nonzero remainder");

endmodule

`default_nettype wire

// File: src/fsfl_cmd_fifo.sv
// ----------------------------------------------------------------------------
// fsfl_cmd_fifo: command queue between front end and list engine
// A short register queue so either side can stall without holding the other.
// ----------------------------------------------------------------------------
`default_nettype none

module fsfl_cmd_fifo #(
  parameter int unsigned SW = 10
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  fsfl_pkg::cmd_t         push_ctl,
  input  wire logic [SW-1:0]     push_idx,
  output logic                   full,
  output logic                   not_empty,
  input  wire logic              pop,
  output fsfl_pkg::cmd_t         head_ctl,
  output logic [SW-1:0]          head_idx
);

  localparam int unsigned DEPTH = fsfl_pkg::CMDQ_DEPTH;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  fsfl_pkg::cmd_t    ctl_q [DEPTH];
  logic [SW-1:0]     idx_q [DEPTH];
  logic [PW-1:0]     wp_r, rp_r;
  logic [CW-1:0]     cnt_r;
  logic              do_push, do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_ctl  = ctl_q[rp_r];
  assign head_idx  = idx_q[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ctl_q[wp_r] <= push_ctl;
      idx_q[wp_r] <= push_idx;
    end
  end

endmodule

`default_nettype wire

// File: src/fsfl_back.sv
// ----------------------------------------------------------------------------
// fsfl_back: free list engine
// Holds the link memory, head and free count; runs the init sweep, carries
// out queued commands and drives the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module fsfl_back #(
  parameter int unsigned MAX_SLOTS = fsfl_pkg::MAX_SLOTS_DEF,
  parameter int unsigned SW   = 10,
  parameter int unsigned LW   = 11,
  parameter int unsigned EBW  = 13,
  parameter int unsigned CNTW = 11
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              sweep_start,
  input  wire logic [EBW-1:0]    eff_bytes,
  input  wire logic [CNTW-1:0]   eff_count,
  input  wire logic              q_valid,
  input  fsfl_pkg::cmd_t         q_ctl,
  input  wire logic [SW-1:0]     q_idx,
  output logic                   q_pop,
  output logic                   sweeping,
  fsfl_rsp_if.source             out_ch
);

  localparam int unsigned        PW        = SW + EBW;
  localparam int unsigned        COUNT_W   = fsfl_pkg::COUNT_W;
  localparam logic [LW-1:0]      NULL_LINK = LW'(MAX_SLOTS);

  typedef enum logic [3:0] {
    B_SWEEP = 4'b0001,
    B_IDLE  = 4'b0010,
    B_READ  = 4'b0100,
    B_OUT   = 4'b1000
  } bstate_t;

  logic [LW-1:0]              links [MAX_SLOTS];

  bstate_t                    state_r, state_nxt;
  logic [SW-1:0]              sweep_idx_r, sweep_idx_nxt;
  logic [LW-1:0]              head_r, head_nxt;
  logic [COUNT_W-1:0]         count_r, count_nxt;
  logic [SW-1:0]              gslot_r, gslot_nxt;
  logic [LW-1:0]              rd_data_r;
  logic [PW-1:0]              prod_r;

  logic                       out_v_r, out_v_nxt;
  fsfl_pkg::status_t          out_status_r, out_status_nxt;
  logic [fsfl_pkg::GSLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [fsfl_pkg::OFF_W-1:0] out_off_r, out_off_nxt;
  logic [COUNT_W-1:0]         out_cnt_r, out_cnt_nxt;

  logic                       mem_we;
  logic [SW-1:0]              mem_wa;
  logic [LW-1:0]              mem_wd;
  logic [CNTW-1:0]            count_m1;
  logic                       sweep_last;
  logic                       head_null;
  logic [COUNT_W-1:0]         count_inc, count_dec;

  assign count_m1   = eff_count - CNTW'(1);
  assign sweep_last = (sweep_idx_r == SW'(count_m1));
  assign head_null  = (head_r == NULL_LINK);
  assign sweeping   = (state_r == B_SWEEP);
  assign count_inc  = (count_r == fsfl_pkg::COUNT_MAX) ? count_r : count_r + 1'b1;
  assign count_dec  = (count_r == '0) ? count_r : count_r - 1'b1;

  assign out_ch.valid          = out_v_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.granted_slot   = out_slot_r;
  assign out_ch.granted_offset = out_off_r;
  assign out_ch.free_count     = out_cnt_r;

  always_comb begin
    state_nxt      = state_r;
    sweep_idx_nxt  = sweep_idx_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    gslot_nxt      = gslot_r;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = sweep_idx_r;
    mem_wd         = head_r;
    out_v_nxt      = out_v_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_off_nxt    = out_off_r;
    out_cnt_nxt    = out_cnt_r;

    unique case (state_r)
      B_SWEEP: begin
        // Slot i links to slot i-1; slot 0 ends the list.
        mem_we = 1'b1;
        mem_wa = sweep_idx_r;
        mem_wd = (sweep_idx_r == '0) ? NULL_LINK : LW'(sweep_idx_r) - 1'b1;
        if (sweep_last) begin
          head_nxt  = LW'(count_m1);
          count_nxt = (eff_count > CNTW'(fsfl_pkg::COUNT_MAX)) ?
                      fsfl_pkg::COUNT_MAX : COUNT_W'(eff_count);
          state_nxt = B_IDLE;
        end else begin
          sweep_idx_nxt = sweep_idx_r + 1'b1;
        end
      end
      B_IDLE: begin
        // Take a command only when the response register is free or draining,
        // so that it stays free until this command's result is written.
        if (q_valid && (!out_v_r || out_ch.ready)) begin
          q_pop        = 1'b1;
          out_slot_nxt = '0;
          out_off_nxt  = '0;
          case (q_ctl.kind)
            fsfl_pkg::CMD_FREE: begin
              mem_we         = 1'b1;
              mem_wa         = q_idx;
              mem_wd         = head_r;
              head_nxt       = LW'(q_idx);
              count_nxt      = count_inc;
              out_v_nxt      = 1'b1;
              out_status_nxt = fsfl_pkg::ST_OK;
              out_cnt_nxt    = count_inc;
            end
            fsfl_pkg::CMD_ALLOC: begin
              if (head_null) begin
                out_v_nxt      = 1'b1;
                out_status_nxt = fsfl_pkg::ST_EMPTY;
                out_cnt_nxt    = count_r;
              end else begin
                gslot_nxt = head_r[SW-1:0];
                state_nxt = B_READ;
              end
            end
            default: begin
              out_v_nxt      = 1'b1;
              out_status_nxt = q_ctl.status;
              out_cnt_nxt    = count_r;
            end
          endcase
        end
      end
      B_READ: begin
        head_nxt  = rd_data_r;
        count_nxt = count_dec;
        state_nxt = B_OUT;
      end
      B_OUT: begin
        out_v_nxt      = 1'b1;
        out_status_nxt = fsfl_pkg::ST_OK;
        out_slot_nxt   = fsfl_pkg::GSLOT_W'(gslot_r);
        out_off_nxt    = fsfl_pkg::OFF_W'(prod_r);
        out_cnt_nxt    = count_r;
        state_nxt      = B_IDLE;
      end
      default: state_nxt = B_SWEEP;
    endcase

    if (sweep_start) begin
      state_nxt     = B_SWEEP;
      sweep_idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_SWEEP;
      sweep_idx_r <= '0;
      head_r      <= NULL_LINK;
      count_r     <= '0;
      out_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_idx_r <= sweep_idx_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gslot_r      <= gslot_nxt;
    prod_r       <= PW'(gslot_r) * PW'(eff_bytes);
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_off_r    <= out_off_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  // Link memory: one write port, one registered read port at the head.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      links[mem_wa] <= mem_wd;
    end
    rd_data_r <= links[head_r[SW-1:0]];
  end

  a_out_free_during_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_READ) || (state_r == B_OUT) |-> !out_v_r)
    else $error("response register busy while an allocate is in flight");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(q_pop) || $past(state_r == B_OUT))
    else $error("response appeared without a command");

  a_sweep_sets_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SWEEP) && sweep_last && !sweep_start |=> !head_null)
    else $error("init sweep left an empty list");

endmodule

`default_nettype wire

// File: src/fixed_slot_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// fixed_slot_free_list_allocator_core: fixed-size pool allocator
// Pool of equal slots managed as a LIFO free list with byte-offset frees.
// ----------------------------------------------------------------------------
// Each request transaction yields exactly one response transaction. An
// allocate reaches the response register through command pop, link memory
// read with the offset multiply beside it, and response load. A free first
// passes the restoring divider in the front end, which turns the 22-bit byte
// offset into a slot index one quotient bit per cycle; the command is then
// classified and queued, and later popped to load the response. The front
// end and the list engine are separated by a two-entry command queue, and
// the response sits in an output register, so a new request can be taken
// while a result waits. After reset and after every configuration write, an
// init sweep rebuilds the descending free list one slot per cycle over
// slot_count slots (clamped to 1..MAX_SLOTS); no request is accepted then.
// Configuration writes are allowed only while the block is idle.
`default_nettype none

module fixed_slot_free_list_allocator_core #(
  parameter int unsigned MAX_SLOTS      = fsfl_pkg::MAX_SLOTS_DEF,
  parameter int unsigned MAX_SLOT_BYTES = fsfl_pkg::MAX_SLOT_BYTES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  fsfl_req_if.sink                              in_ch,
  fsfl_rsp_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [fsfl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fsfl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int unsigned SW   = $clog2(MAX_SLOTS);
  localparam int unsigned LW   = $clog2(MAX_SLOTS + 1);
  localparam int unsigned EBW  = $clog2(MAX_SLOT_BYTES + 1);
  localparam int unsigned BCW  = (EBW > fsfl_pkg::SLOT_BYTES_W) ? EBW : fsfl_pkg::SLOT_BYTES_W;
  localparam int unsigned CNTW = (LW > fsfl_pkg::SLOT_COUNT_W) ? LW : fsfl_pkg::SLOT_COUNT_W;

  logic [fsfl_pkg::SLOT_BYTES_W-1:0] slot_bytes_r;
  logic [fsfl_pkg::SLOT_COUNT_W-1:0] slot_count_r;
  logic [BCW-1:0]                    bytes_wide;
  logic [CNTW-1:0]                   count_wide;
  logic [EBW-1:0]                    eff_bytes;
  logic [CNTW-1:0]                   eff_count;

  logic                              sweeping;
  logic                              push, q_full, q_valid, q_pop;
  fsfl_pkg::cmd_t                    push_ctl, q_ctl;
  logic [SW-1:0]                     push_idx, q_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_bytes_r <= fsfl_pkg::SLOT_BYTES_RST;
      slot_count_r <= fsfl_pkg::SLOT_COUNT_RST;
    end else if (cfg_we) begin
      unique case (fsfl_pkg::cfg_reg_t'(cfg_index))
        fsfl_pkg::CFG_SLOT_BYTES: slot_bytes_r <= cfg_wdata;
        fsfl_pkg::CFG_SLOT_COUNT: slot_count_r <= cfg_wdata[fsfl_pkg::SLOT_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register values outside the supported range are clamped.
  always_comb begin
    bytes_wide = BCW'(slot_bytes_r);
    if (bytes_wide < BCW'(fsfl_pkg::MIN_SLOT_BYTES)) begin
      bytes_wide = BCW'(fsfl_pkg::MIN_SLOT_BYTES);
    end else if (bytes_wide > BCW'(MAX_SLOT_BYTES)) begin
      bytes_wide = BCW'(MAX_SLOT_BYTES);
    end
    eff_bytes = EBW'(bytes_wide);

    count_wide = CNTW'(slot_count_r);
    if (count_wide == '0) begin
      count_wide = CNTW'(1);
    end else if (count_wide > CNTW'(MAX_SLOTS)) begin
      count_wide = CNTW'(MAX_SLOTS);
    end
    eff_count = count_wide;
  end

  fsfl_front #(
    .SW   (SW),
    .EBW  (EBW),
    .CNTW (CNTW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .eff_bytes (eff_bytes),
    .eff_count (eff_count),
    .sweeping  (sweeping),
    .cfg_we    (cfg_we),
    .q_full    (q_full),
    .push      (push),
    .cmd_ctl   (push_ctl),
    .cmd_idx   (push_idx)
  );

  fsfl_cmd_fifo #(
    .SW (SW)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_idx  (push_idx),
    .full      (q_full),
    .not_empty (q_valid),
    .pop       (q_pop),
    .head_ctl  (q_ctl),
    .head_idx  (q_idx)
  );

  fsfl_back #(
    .MAX_SLOTS (MAX_SLOTS),
    .SW        (SW),
    .LW        (LW),
    .EBW       (EBW),
    .CNTW      (CNTW)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .sweep_start (cfg_we),
    .eff_bytes   (eff_bytes),
    .eff_count   (eff_count),
    .q_valid     (q_valid),
    .q_ctl       (q_ctl),
    .q_idx       (q_idx),
    .q_pop       (q_pop),
    .sweeping    (sweeping),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

// File: verif/tb_fixed_slot_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_fixed_slot_free_list_allocator_core: self-checking bench for the allocator
// Drives allocate and free transactions through the request channel, keeps a
// shadow free list that predicts every response, and checks each response
// field by field. Directed tests cover the field limits and every status
// code. Randomized traffic then runs over several pool shapes. The request
// side sends in bursts and the response side stalls on its own pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fixed_slot_free_list_allocator_core;
  import fsfl_pkg::*;

  localparam int unsigned STALL_LIMIT = 6000;
  localparam int unsigned SWEEP_WAIT  = 1100;
  localparam int unsigned DRAIN_TAIL  = 40;
  localparam logic [COUNT_W-1:0] NULL_LINK = 11'd1024;

  typedef struct packed {
    status_t              status;
    logic [GSLOT_W-1:0]   slot;
    logic [OFF_W-1:0]     offset;
    logic [COUNT_W-1:0]   count;
  } pool_rsp_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fsfl_req_if in_ch ();
  fsfl_rsp_if out_ch ();

  fixed_slot_free_list_allocator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the pool.
  logic [SLOT_BYTES_W-1:0] shadow_bytes;
  logic [SLOT_COUNT_W-1:0] shadow_count;
  logic [COUNT_W-1:0]      link_mem [0:MAX_SLOTS_DEF-1];
  logic [COUNT_W-1:0]      head_slot;
  logic [COUNT_W-1:0]      free_total;

  pool_rsp_t        pending_rsp [$];
  logic [OFF_W-1:0] owned_offsets [$];

  int unsigned mismatch_count = 0;
  int unsigned rsp_seen = 0;
  int unsigned stall_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  int unsigned rx_phase = 0;

  function automatic int unsigned slot_size();
    int unsigned b;
    b = shadow_bytes;
    if (b < MIN_SLOT_BYTES) b = MIN_SLOT_BYTES;
    if (b > MAX_SLOT_BYTES_DEF) b = MAX_SLOT_BYTES_DEF;
    return b;
  endfunction

  function automatic int unsigned pool_slots();
    int unsigned c;
    c = shadow_count;
    if (c < 1) c = 1;
    if (c > MAX_SLOTS_DEF) c = MAX_SLOTS_DEF;
    return c;
  endfunction

  // Chains slot i to slot i-1 with slot 0 at the end of the list.
  function automatic void rebuild_list();
    int unsigned c;
    c = pool_slots();
    link_mem[0] = NULL_LINK;
    for (int unsigned i = 1; i < c; i++) link_mem[i] = 11'(i - 1);
    head_slot = 11'(c - 1);
    free_total = 11'(c);
  endfunction

  function automatic pool_rsp_t apply_request(req_t kind, logic [SIZE_W-1:0] size,
                                              logic [OFF_W-1:0] off);
    int unsigned b;
    int unsigned c;
    int unsigned idx;
    logic [31:0] prod;
    pool_rsp_t r;
    b = slot_size();
    c = pool_slots();
    r.status = ST_OK;
    r.slot = '0;
    r.offset = '0;
    if (kind == REQ_ALLOC) begin
      if (size > b) begin
        r.status = ST_TOO_LARGE;
      end else if (head_slot >= NULL_LINK) begin
        r.status = ST_EMPTY;
      end else begin
        r.slot = head_slot[GSLOT_W-1:0];
        prod = head_slot * b;
        r.offset = prod[OFF_W-1:0];
        head_slot = link_mem[head_slot[GSLOT_W-1:0]];
        if (free_total != 0) free_total = free_total - 1'b1;
      end
    end else begin
      idx = off / b;
      if (off % b != 0) begin
        r.status = ST_MISALIGN;
      end else if (idx >= c) begin
        r.status = ST_RANGE;
      end else begin
        link_mem[idx] = head_slot;
        head_slot = 11'(idx);
        if (free_total != COUNT_MAX) free_total = free_total + 1'b1;
      end
    end
    r.count = free_total;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at response %0d: %s got %0d expected %0d", rsp_seen, what, got,
             want);
    mismatch_count++;
  endtask

  task automatic check_response();
    pool_rsp_t want;
    if (pending_rsp.size() == 0) begin
      report_mismatch("unexpected response, status", out_ch.status, 0);
    end else begin
      want = pending_rsp.pop_front();
      if (out_ch.status !== want.status)
        report_mismatch("status", out_ch.status, want.status);
      if (out_ch.granted_slot !== want.slot)
        report_mismatch("granted_slot", out_ch.granted_slot, want.slot);
      if (out_ch.granted_offset !== want.offset)
        report_mismatch("granted_offset", out_ch.granted_offset, want.offset);
      if (out_ch.free_count !== want.count)
        report_mismatch("free_count", out_ch.free_count, want.count);
    end
    rsp_seen++;
  endtask

  // Sends one request transaction and records its predicted response. The
  // valid line stays high on return so that back-to-back requests leave no
  // gap between them; a gap is only opened when a burst runs out.
  task automatic send_request(req_t kind, logic [SIZE_W-1:0] size,
                              logic [OFF_W-1:0] off, output pool_rsp_t rsp);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.req_type <= kind;
    in_ch.request_size <= size;
    in_ch.freed_offset <= off;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    rsp = apply_request(kind, size, off);
    pending_rsp.push_back(rsp);
  endtask

  task automatic wait_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // Writes a register once the pool is idle, then rebuilds the shadow list
  // just as the block restarts its init sweep.
  task automatic write_pool_reg(cfg_reg_t which, logic [CFG_DATA_W-1:0] value);
    int unsigned n;
    wait_results();
    n = 0;
    while (in_ch.ready !== 1'b1 && n < SWEEP_WAIT) begin
      @(posedge clk);
      n++;
    end
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (which == CFG_SLOT_BYTES) shadow_bytes = value;
    else shadow_count = value[SLOT_COUNT_W-1:0];
    rebuild_list();
    owned_offsets.delete();
  endtask

  task automatic test_default_pool();
    pool_rsp_t r;
    send_request(REQ_ALLOC, 16'd0, '0, r);
    send_request(REQ_ALLOC, 16'd64, '0, r);
    send_request(REQ_ALLOC, 16'd65, '0, r);
    send_request(REQ_ALLOC, 16'hFFFF, '0, r);
    send_request(REQ_FREE, '0, 22'd65472, r);
    send_request(REQ_FREE, '0, 22'd1, r);
    send_request(REQ_FREE, '0, 22'h3FFFFF, r);
    send_request(REQ_FREE, '0, 22'd65536, r);
    send_request(REQ_FREE, '0, 22'd4194240, r);
    // Freeing the same slot twice goes unnoticed and raises the count.
    send_request(REQ_FREE, '0, 22'd65472, r);
    send_request(REQ_ALLOC, 16'd1, '0, r);
  endtask

  task automatic test_tiny_pool();
    pool_rsp_t r;
    write_pool_reg(CFG_SLOT_BYTES, 13'd4);
    write_pool_reg(CFG_SLOT_COUNT, 13'd1);
    send_request(REQ_ALLOC, 16'd4, '0, r);
    send_request(REQ_ALLOC, 16'd0, '0, r);
    // The size test wins over the empty test.
    send_request(REQ_ALLOC, 16'd5, '0, r);
    send_request(REQ_FREE, '0, 22'd2, r);
    send_request(REQ_FREE, '0, 22'd4, r);
    send_request(REQ_FREE, '0, 22'd0, r);
    send_request(REQ_FREE, '0, 22'd0, r);
    // The slot now links to itself, so allocation goes on past a zero count.
    send_request(REQ_ALLOC, 16'd3, '0, r);
    send_request(REQ_ALLOC, 16'd3, '0, r);
    send_request(REQ_ALLOC, 16'd3, '0, r);
  endtask

  task automatic test_clamped_registers();
    pool_rsp_t r;
    write_pool_reg(CFG_SLOT_BYTES, 13'd0);
    write_pool_reg(CFG_SLOT_COUNT, 13'd0);
    send_request(REQ_ALLOC, 16'd4, '0, r);
    send_request(REQ_ALLOC, 16'd5, '0, r);
    write_pool_reg(CFG_SLOT_BYTES, 13'h1FFF);
    write_pool_reg(CFG_SLOT_COUNT, 13'd2047);
    send_request(REQ_ALLOC, 16'd4096, '0, r);
    send_request(REQ_ALLOC, 16'd4097, '0, r);
    send_request(REQ_FREE, '0, 22'd4190208, r);
    send_request(REQ_FREE, '0, 22'h3FFFFF, r);
  endtask

  // Repeated frees into a full pool drive the count into its ceiling.
  task automatic test_count_ceiling();
    pool_rsp_t r;
    logic [31:0] prod;
    write_pool_reg(CFG_SLOT_BYTES, 13'd64);
    write_pool_reg(CFG_SLOT_COUNT, 13'd1024);
    for (int n = 0; n < 1030; n++) begin
      prod = $urandom_range(0, 1023) * 64;
      send_request(REQ_FREE, 16'($urandom), prod[OFF_W-1:0], r);
    end
    for (int n = 0; n < 4; n++) send_request(REQ_ALLOC, 16'($urandom_range(0, 64)), '0, r);
    wait_results();
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_slot_bytes();
    case ($urandom_range(0, 7))
      0:       return 13'($urandom_range(0, 3));
      1:       return 13'd4;
      2:       return 13'd4096;
      3:       return 13'($urandom_range(4097, 8191));
      4:       return 13'(1 << $urandom_range(2, 12));
      default: return 13'($urandom_range(4, 4096));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_slot_count();
    logic [SLOT_COUNT_W-1:0] c;
    case ($urandom_range(0, 7))
      0:       c = 11'd0;
      1:       c = 11'd1;
      2:       c = 11'($urandom_range(2, 8));
      3:       c = 11'($urandom_range(9, 64));
      4:       c = 11'd1024;
      5:       c = 11'($urandom_range(1025, 2047));
      default: c = 11'($urandom_range(1, 1024));
    endcase
    // Bits above the register width are dropped by the block.
    return {2'($urandom_range(0, 3)), c};
  endfunction

  task automatic test_random_traffic();
    pool_rsp_t r;
    req_t kind;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0] off;
    logic [31:0] prod;
    int unsigned b;
    int unsigned c;
    int unsigned pick;
    int unsigned k;
    for (int phase = 0; phase < 9; phase++) begin
      if ($urandom_range(0, 1) == 0) begin
        write_pool_reg(CFG_SLOT_BYTES, pick_slot_bytes());
        write_pool_reg(CFG_SLOT_COUNT, pick_slot_count());
      end else begin
        write_pool_reg(CFG_SLOT_COUNT, pick_slot_count());
        write_pool_reg(CFG_SLOT_BYTES, pick_slot_bytes());
      end
      b = slot_size();
      c = pool_slots();
      for (int n = 0; n < 32; n++) begin
        pick = $urandom_range(0, 99);
        size = 16'($urandom);
        off = 22'($urandom);
        if (pick < 45) begin
          kind = REQ_ALLOC;
          if ($urandom_range(0, 99) < 85) size = 16'($urandom_range(0, b));
          else size = 16'($urandom_range(b + 1, 65535));
        end else if (pick < 80) begin
          kind = REQ_FREE;
          if (owned_offsets.size() != 0) begin
            k = $urandom_range(0, owned_offsets.size() - 1);
            off = owned_offsets[k];
            owned_offsets.delete(k);
          end else begin
            prod = $urandom_range(0, c - 1) * b;
            off = prod[OFF_W-1:0];
          end
        end else if (pick < 90) begin
          // Aligned frees around the top of the pool, double frees included.
          kind = REQ_FREE;
          prod = $urandom_range(0, c + 4) * b;
          off = prod[OFF_W-1:0];
        end else begin
          kind = req_t'($urandom_range(0, 1));
        end
        send_request(kind, size, off, r);
        if (kind == REQ_ALLOC && r.status == ST_OK) owned_offsets.push_back(r.offset);
        if ($urandom_range(0, 59) == 0) wait_results();
      end
    end
  endtask

  // Response side: checks each transaction, keeps the stall counter and
  // varies ready over stretches of different patterns.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_response();
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
        2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= (rx_phase % 5 == 0);
      endcase
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.req_type <= REQ_ALLOC;
    in_ch.request_size <= '0;
    in_ch.freed_offset <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_SLOT_BYTES;
    cfg_wdata <= '0;
    shadow_bytes = SLOT_BYTES_RST;
    shadow_count = SLOT_COUNT_RST;
    for (int i = 0; i < MAX_SLOTS_DEF; i++) link_mem[i] = '0;
    rebuild_list();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_default_pool();
    test_tiny_pool();
    test_clamped_registers();
    test_count_ceiling();
    test_random_traffic();

    wait_results();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (pending_rsp.size() != 0) report_mismatch("responses missing", 0, pending_rsp.size());
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
